/* rtl/bicdf_pkg.sv */
// ------------------------------------------------------------------------------------------
// bicdf_pkg: shared constants and types of the bilinear inverse-CDF lookup
// Grid sizes, fixed-point widths, command and register codes, and the structs that
// carry a transaction between the pipeline stages.
// ------------------------------------------------------------------------------------------
package bicdf_pkg;

    // Grid of the angle table: rows follow the shape parameter, columns the probability.
    localparam int B_ROWS    = 64;
    localparam int U_COLUMNS = 1024;
    localparam int ROW_W     = $clog2(B_ROWS);
    localparam int COL_W     = $clog2(U_COLUMNS);
    localparam int HROW_W    = ROW_W - 1;
    localparam int HCOL_W    = COL_W - 1;
    localparam int BANK_AW   = HROW_W + HCOL_W;
    localparam int BANKS     = 4;

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int REG_W     = 2;
    localparam int CFG_W     = 24;
    localparam int B_W       = 24;
    localparam int U_W       = 17;
    localparam int RECIP_W   = 20;
    localparam int ANG_W     = 20;
    localparam int MSQ_W     = 24;

    // Fixed-point working widths.
    localparam int FRAC      = 16;
    localparam int W_W       = FRAC + 1;
    localparam int G_W       = B_W + RECIP_W;
    localparam int J_W       = G_W - 2 * FRAC;
    localparam int GU_W      = U_W + COL_W;
    localparam int LERP_W    = MSQ_W + W_W + 2;

    localparam logic [W_W-1:0]   ONE_Q16   = W_W'(1 << FRAC);
    localparam logic [ANG_W-1:0] ANGLE_MAX = ANG_W'(786432);

    // Register reset values.
    localparam logic [B_W-1:0]     B_LOWER_RST = B_W'(104858);
    localparam logic [B_W-1:0]     B_UPPER_RST = B_W'(2621440);
    localparam logic [RECIP_W-1:0] B_RECIP_RST = RECIP_W'(107520);

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_ANGLE = 2'd0,
        CMD_WRITE_MSQ   = 2'd1,
        CMD_LOOKUP      = 2'd2
    } t_cmd;

    typedef enum logic [REG_W-1:0] {
        REG_B_LOWER = 2'd0,
        REG_B_UPPER = 2'd1,
        REG_B_RECIP = 2'd2
    } t_reg_idx;

    // Transaction after the row-coordinate multiply.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [MSQ_W-1:0] wval;
        logic [G_W-1:0]   g;
        logic [COL_W-1:0] k;
        logic [W_W-1:0]   fu;
        logic             bzero;
    } t_coord;

    // Transaction after the table reads.
    typedef struct packed {
        logic                        row_par;
        logic                        col_par;
        logic [W_W-1:0]              fu;
        logic [W_W-1:0]              fb;
        logic                        bzero;
        logic [BANKS-1:0][ANG_W-1:0] bank_q;
        logic [MSQ_W-1:0]            msq_lo;
        logic [MSQ_W-1:0]            msq_hi;
    } t_fetch;

endpackage

/* rtl/bicdf_ram.sv */
// ------------------------------------------------------------------------------------------
// bicdf_ram: simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ------------------------------------------------------------------------------------------
module bicdf_ram #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 20
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bicdf_coord.sv */
// ------------------------------------------------------------------------------------------
// bicdf_coord: grid coordinates of a transaction
// Stage one clamps B and u and finds the column bracket; stage two forms the row
// coordinate with one multiply.
// ------------------------------------------------------------------------------------------
module bicdf_coord (
    input  logic                              i_clk,
    input  logic                              i_en1,
    input  logic                              i_en2,
    input  logic [bicdf_pkg::CMD_W-1:0]       i_command,
    input  logic [bicdf_pkg::ROW_W-1:0]       i_row_index,
    input  logic [bicdf_pkg::COL_W-1:0]       i_column_index,
    input  logic [bicdf_pkg::MSQ_W-1:0]       i_write_value,
    input  logic [bicdf_pkg::B_W-1:0]         i_shape_b,
    input  logic [bicdf_pkg::U_W-1:0]         i_probability,
    input  logic [bicdf_pkg::B_W-1:0]         i_b_lower,
    input  logic [bicdf_pkg::B_W-1:0]         i_b_upper,
    input  logic [bicdf_pkg::RECIP_W-1:0]     i_b_recip,
    output bicdf_pkg::t_coord                 o_coord
);

    logic [bicdf_pkg::B_W-1:0]   n_off;
    logic [bicdf_pkg::U_W-1:0]   uc;
    logic [bicdf_pkg::GU_W-1:0]  gu;
    logic [bicdf_pkg::COL_W:0]   k_raw;
    logic                        k_top;
    logic [bicdf_pkg::COL_W-1:0] n_k;
    logic [bicdf_pkg::W_W-1:0]   n_fu;

    logic [bicdf_pkg::CMD_W-1:0] r1_cmd;
    logic [bicdf_pkg::ROW_W-1:0] r1_row;
    logic [bicdf_pkg::COL_W-1:0] r1_col;
    logic [bicdf_pkg::MSQ_W-1:0] r1_wval;
    logic [bicdf_pkg::B_W-1:0]   r1_off;
    logic [bicdf_pkg::COL_W-1:0] r1_k;
    logic [bicdf_pkg::W_W-1:0]   r1_fu;
    logic                        r1_bzero;
    bicdf_pkg::t_coord           r_s2;

    // Offset of the clamped B above the lower bound; crossed bounds give zero.
    always_comb begin
        if (i_shape_b < i_b_lower) begin
            n_off = '0;
        end else if (i_shape_b > i_b_upper) begin
            n_off = (i_b_upper > i_b_lower) ? (i_b_upper - i_b_lower) : '0;
        end else begin
            n_off = i_shape_b - i_b_lower;
        end
    end

    // Column bracket. Past the last node the weight is always a whole step.
    always_comb begin
        uc    = (i_probability > bicdf_pkg::ONE_Q16) ? bicdf_pkg::ONE_Q16 : i_probability;
        gu    = bicdf_pkg::GU_W'(uc) * bicdf_pkg::GU_W'(bicdf_pkg::U_COLUMNS - 1);
        k_raw = gu[bicdf_pkg::GU_W-1:bicdf_pkg::FRAC];
        k_top = k_raw >= (bicdf_pkg::COL_W + 1)'(bicdf_pkg::U_COLUMNS - 1);
        n_k   = k_top ? bicdf_pkg::COL_W'(bicdf_pkg::U_COLUMNS - 2)
                      : k_raw[bicdf_pkg::COL_W-1:0];
        n_fu  = k_top ? bicdf_pkg::ONE_Q16 : {1'b0, gu[bicdf_pkg::FRAC-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r1_cmd   <= i_command;
            r1_row   <= i_row_index;
            r1_col   <= i_column_index;
            r1_wval  <= i_write_value;
            r1_off   <= n_off;
            r1_k     <= n_k;
            r1_fu    <= n_fu;
            r1_bzero <= (i_shape_b == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_s2.cmd   <= r1_cmd;
            r_s2.row   <= r1_row;
            r_s2.col   <= r1_col;
            r_s2.wval  <= r1_wval;
            r_s2.g     <= bicdf_pkg::G_W'(r1_off) * bicdf_pkg::G_W'(i_b_recip);
            r_s2.k     <= r1_k;
            r_s2.fu    <= r1_fu;
            r_s2.bzero <= r1_bzero;
        end
    end

    assign o_coord = r_s2;

endmodule

/* rtl/bicdf_table.sv */
// ------------------------------------------------------------------------------------------
// bicdf_table: angle and mean-square tables
// The angle table is split into four banks by row and column parity, so that the four
// corners of a cell are read in the same cycle. Table writes are applied at the same stage.
// ------------------------------------------------------------------------------------------
module bicdf_table (
    input  logic              i_clk,
    input  logic              i_en3,
    input  logic              i_wr_go,
    input  bicdf_pkg::t_coord i_coord,
    output bicdf_pkg::t_fetch o_fetch
);

    logic [bicdf_pkg::J_W-1:0]    j_raw;
    logic                         j_top;
    logic [bicdf_pkg::ROW_W-1:0]  j;
    logic [bicdf_pkg::ROW_W-1:0]  j_nxt;
    logic [bicdf_pkg::W_W-1:0]    fb;
    logic [bicdf_pkg::HROW_W-1:0] re_half;
    logic [bicdf_pkg::HROW_W-1:0] ro_half;
    logic [bicdf_pkg::HCOL_W-1:0] ce_half;
    logic [bicdf_pkg::HCOL_W-1:0] co_half;
    logic                         row_ok;
    logic                         col_ok;
    logic                         ang_we;
    logic                         msq_we;
    logic [1:0]                   wbank;
    logic [bicdf_pkg::BANK_AW-1:0] waddr;

    logic [bicdf_pkg::BANKS-1:0][bicdf_pkg::ANG_W-1:0] bank_q;

    logic [bicdf_pkg::MSQ_W-1:0]  r_msq_mem [bicdf_pkg::B_ROWS];
    logic [bicdf_pkg::MSQ_W-1:0]  r_msq_lo;
    logic [bicdf_pkg::MSQ_W-1:0]  r_msq_hi;
    logic                         r_row_par;
    logic                         r_col_par;
    logic [bicdf_pkg::W_W-1:0]    r_fu;
    logic [bicdf_pkg::W_W-1:0]    r_fb;
    logic                         r_bzero;

    // Row bracket. At or beyond the last row the weight saturates to the last row.
    always_comb begin
        j_raw = i_coord.g[bicdf_pkg::G_W-1:2*bicdf_pkg::FRAC];
        j_top = j_raw >= bicdf_pkg::J_W'(bicdf_pkg::B_ROWS - 1);
        j     = j_top ? bicdf_pkg::ROW_W'(bicdf_pkg::B_ROWS - 2) : j_raw[bicdf_pkg::ROW_W-1:0];
        j_nxt = j + bicdf_pkg::ROW_W'(1);
        fb    = j_top ? bicdf_pkg::ONE_Q16
                      : {1'b0, i_coord.g[2*bicdf_pkg::FRAC-1:bicdf_pkg::FRAC]};
    end

    // Half-indices of the even and odd neighbours among the bracketing rows and columns.
    always_comb begin
        ro_half = j[bicdf_pkg::ROW_W-1:1];
        re_half = j[bicdf_pkg::ROW_W-1:1] + bicdf_pkg::HROW_W'(j[0]);
        co_half = i_coord.k[bicdf_pkg::COL_W-1:1];
        ce_half = i_coord.k[bicdf_pkg::COL_W-1:1] + bicdf_pkg::HCOL_W'(i_coord.k[0]);
    end

    always_comb begin
        row_ok = {1'b0, i_coord.row} < (bicdf_pkg::ROW_W + 1)'(bicdf_pkg::B_ROWS);
        col_ok = {1'b0, i_coord.col} < (bicdf_pkg::COL_W + 1)'(bicdf_pkg::U_COLUMNS);
        ang_we = i_wr_go && (i_coord.cmd == bicdf_pkg::CMD_WRITE_ANGLE) && row_ok && col_ok;
        msq_we = i_wr_go && (i_coord.cmd == bicdf_pkg::CMD_WRITE_MSQ) && row_ok;
        wbank  = {i_coord.row[0], i_coord.col[0]};
        waddr  = {i_coord.row[bicdf_pkg::ROW_W-1:1], i_coord.col[bicdf_pkg::COL_W-1:1]};
    end

    for (genvar gb = 0; gb < bicdf_pkg::BANKS; gb++) begin : g_bank
        localparam bit RP = (gb >= 2);
        localparam bit CP = ((gb % 2) == 1);

        bicdf_ram #(
            .ADDR_W (bicdf_pkg::BANK_AW),
            .DATA_W (bicdf_pkg::ANG_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ang_we && (wbank == 2'(gb))),
            .i_waddr (waddr),
            .i_wdata (i_coord.wval[bicdf_pkg::ANG_W-1:0]),
            .i_re    (i_en3),
            .i_raddr ({(RP ? ro_half : re_half), (CP ? co_half : ce_half)}),
            .o_rdata (bank_q[gb])
        );
    end

    always_ff @(posedge i_clk) begin
        if (msq_we) begin
            r_msq_mem[i_coord.row] <= i_coord.wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_msq_lo  <= r_msq_mem[j];
            r_msq_hi  <= r_msq_mem[j_nxt];
            r_row_par <= j[0];
            r_col_par <= i_coord.k[0];
            r_fu      <= i_coord.fu;
            r_fb      <= fb;
            r_bzero   <= i_coord.bzero;
        end
    end

    always_comb begin
        o_fetch.row_par = r_row_par;
        o_fetch.col_par = r_col_par;
        o_fetch.fu      = r_fu;
        o_fetch.fb      = r_fb;
        o_fetch.bzero   = r_bzero;
        o_fetch.bank_q  = bank_q;
        o_fetch.msq_lo  = r_msq_lo;
        o_fetch.msq_hi  = r_msq_hi;
    end

endmodule

/* rtl/bicdf_interp.sv */
// ------------------------------------------------------------------------------------------
// bicdf_interp: bilinear interpolation
// Stage four interpolates both bracketing rows along u and the mean square along B;
// stage five interpolates along B, saturates (or gives zero for a zero B) and holds the result.
// ------------------------------------------------------------------------------------------
module bicdf_interp (
    input  logic                          i_clk,
    input  logic                          i_en4,
    input  logic                          i_en5,
    input  bicdf_pkg::t_fetch             i_fetch,
    output logic [bicdf_pkg::ANG_W-1:0]   o_reduced_angle,
    output logic [bicdf_pkg::MSQ_W-1:0]   o_mean_square
);

    // (a*(1-w) + c*w) >> 16, rewritten as (a<<16 + (c-a)*w) >> 16 with one multiply.
    function automatic logic [bicdf_pkg::MSQ_W-1:0] lerp(
        input logic [bicdf_pkg::MSQ_W-1:0] a,
        input logic [bicdf_pkg::MSQ_W-1:0] c,
        input logic [bicdf_pkg::W_W-1:0]   w
    );
        logic signed [bicdf_pkg::MSQ_W:0]    diff;
        logic signed [bicdf_pkg::LERP_W-1:0] prod;
        logic signed [bicdf_pkg::LERP_W-1:0] acc;
        diff = signed'({1'b0, c}) - signed'({1'b0, a});
        prod = bicdf_pkg::LERP_W'(diff) * bicdf_pkg::LERP_W'(signed'({1'b0, w}));
        acc  = signed'({{(bicdf_pkg::LERP_W - bicdf_pkg::MSQ_W - bicdf_pkg::FRAC){1'b0}},
                        a, {bicdf_pkg::FRAC{1'b0}}}) + prod;
        return acc[bicdf_pkg::FRAC +: bicdf_pkg::MSQ_W];
    endfunction

    logic [bicdf_pkg::ANG_W-1:0] a00;
    logic [bicdf_pkg::ANG_W-1:0] a01;
    logic [bicdf_pkg::ANG_W-1:0] a10;
    logic [bicdf_pkg::ANG_W-1:0] a11;
    logic [bicdf_pkg::MSQ_W-1:0] n_r0;
    logic [bicdf_pkg::MSQ_W-1:0] n_r1;
    logic [bicdf_pkg::MSQ_W-1:0] n_ang;

    logic [bicdf_pkg::ANG_W-1:0] r_r0;
    logic [bicdf_pkg::ANG_W-1:0] r_r1;
    logic [bicdf_pkg::MSQ_W-1:0] r_msq;
    logic [bicdf_pkg::W_W-1:0]   r_fb;
    logic                        r_bzero;
    logic [bicdf_pkg::ANG_W-1:0] r_angle_out;
    logic [bicdf_pkg::MSQ_W-1:0] r_msq_out;

    // Bank index is {row parity, column parity}.
    always_comb begin
        a00  = i_fetch.bank_q[{ i_fetch.row_par,  i_fetch.col_par}];
        a01  = i_fetch.bank_q[{ i_fetch.row_par, ~i_fetch.col_par}];
        a10  = i_fetch.bank_q[{~i_fetch.row_par,  i_fetch.col_par}];
        a11  = i_fetch.bank_q[{~i_fetch.row_par, ~i_fetch.col_par}];
        n_r0 = lerp(bicdf_pkg::MSQ_W'(a00), bicdf_pkg::MSQ_W'(a01), i_fetch.fu);
        n_r1 = lerp(bicdf_pkg::MSQ_W'(a10), bicdf_pkg::MSQ_W'(a11), i_fetch.fu);
    end

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            r_r0    <= n_r0[bicdf_pkg::ANG_W-1:0];
            r_r1    <= n_r1[bicdf_pkg::ANG_W-1:0];
            r_msq   <= lerp(i_fetch.msq_lo, i_fetch.msq_hi, i_fetch.fb);
            r_fb    <= i_fetch.fb;
            r_bzero <= i_fetch.bzero;
        end
    end

    assign n_ang = lerp(bicdf_pkg::MSQ_W'(r_r0), bicdf_pkg::MSQ_W'(r_r1), r_fb);

    always_ff @(posedge i_clk) begin
        if (i_en5) begin
            if (r_bzero) begin
                r_angle_out <= '0;
            end else if (n_ang > bicdf_pkg::MSQ_W'(bicdf_pkg::ANGLE_MAX)) begin
                r_angle_out <= bicdf_pkg::ANGLE_MAX;
            end else begin
                r_angle_out <= n_ang[bicdf_pkg::ANG_W-1:0];
            end
            r_msq_out <= r_msq;
        end
    end

    assign o_reduced_angle = r_angle_out;
    assign o_mean_square   = r_msq_out;

endmodule

/* rtl/bilinear_inverse_cdf_lookup_top.sv */
// ------------------------------------------------------------------------------------------
// bilinear_inverse_cdf_lookup_top: inverse-transform sampling by bilinear table lookup
// Five-stage pipeline that loads an angle table and a mean-square table and answers
// lookups with the interpolated reduced angle and mean square.
// ------------------------------------------------------------------------------------------
// The block accepts one transaction per clock cycle while o_stall is low and returns the
// result of a lookup once it has passed through every stage. Each transaction is
// either a table write (angle or mean square), which produces no result, or a lookup;
// the reserved command code is dropped at the input. Throughput is set by the angle
// table, which is held in four RAM banks split by row and column parity so that all four
// corners of a grid cell are read in the same cycle, and by the mean-square table with
// its two read ports. Writes are applied at the same pipeline stage as the reads, so a
// lookup always sees every write accepted before it and none accepted after it. The
// tables are not cleared after reset: an entry must be written before a lookup uses it.
// Configuration registers (B bounds and step reciprocal) may only be written while the
// pipeline is empty; the configuration port is always ready.
//
// Pipeline: stage one clamps B and u and brackets the column, stage two forms the row
// coordinate, stage three brackets the row and reads the tables, stage four
// interpolates along u (and the mean square along B), stage five interpolates the angle
// along B and holds the result for the output transaction. Each stage advances when it
// is empty or when the stage after it advances, so bubbles close up and a stalled output
// does not block input until the pipeline is full.

module bilinear_inverse_cdf_lookup_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel.
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bicdf_pkg::CMD_W-1:0]       i_command,
    input  logic [bicdf_pkg::ROW_W-1:0]       i_row_index,
    input  logic [bicdf_pkg::COL_W-1:0]       i_column_index,
    input  logic [bicdf_pkg::MSQ_W-1:0]       i_write_value,
    input  logic [bicdf_pkg::B_W-1:0]         i_shape_b,
    input  logic [bicdf_pkg::U_W-1:0]         i_probability,
    // Output channel.
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bicdf_pkg::ANG_W-1:0]       o_reduced_angle,
    output logic [bicdf_pkg::MSQ_W-1:0]       o_mean_square,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bicdf_pkg::REG_W-1:0]       i_cfg_index,
    input  logic [bicdf_pkg::CFG_W-1:0]       i_cfg_data
);

    // Configuration registers.
    logic [bicdf_pkg::B_W-1:0]     r_b_lower;
    logic [bicdf_pkg::B_W-1:0]     r_b_upper;
    logic [bicdf_pkg::RECIP_W-1:0] r_b_recip;

    // Stage valid bits and their next values.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic n_v1, n_v2, n_v3, n_v4, n_v5;

    // Stage advance enables.
    logic en1, en2, en3, en4, en5;
    logic cmd_ok;

    bicdf_pkg::t_coord coord;
    bicdf_pkg::t_fetch fetch;

    // A stage takes a new transaction when it is empty or its contents move on.
    always_comb begin
        en5 = !r_v5 || !i_stall;
        en4 = !r_v4 || en5;
        en3 = !r_v3 || en4;
        en2 = !r_v2 || en3;
        en1 = !r_v1 || en2;
    end

    assign o_stall = !en1;
    assign o_valid = r_v5;

    always_comb begin
        cmd_ok = (i_command == bicdf_pkg::CMD_WRITE_ANGLE) ||
                 (i_command == bicdf_pkg::CMD_WRITE_MSQ) ||
                 (i_command == bicdf_pkg::CMD_LOOKUP);
        n_v1 = en1 ? (i_valid && cmd_ok) : r_v1;
        n_v2 = en2 ? r_v1 : r_v2;
        // Table writes retire at stage three; only lookups travel on.
        n_v3 = en3 ? (r_v2 && (coord.cmd == bicdf_pkg::CMD_LOOKUP)) : r_v3;
        n_v4 = en4 ? r_v3 : r_v4;
        n_v5 = en5 ? r_v4 : r_v5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
            r_v5 <= n_v5;
        end
    end

    // Configuration writes. An index beyond the register list is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_lower <= bicdf_pkg::B_LOWER_RST;
            r_b_upper <= bicdf_pkg::B_UPPER_RST;
            r_b_recip <= bicdf_pkg::B_RECIP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bicdf_pkg::t_reg_idx'(i_cfg_index))
                bicdf_pkg::REG_B_LOWER: begin
                    r_b_lower <= i_cfg_data[bicdf_pkg::B_W-1:0];
                end
                bicdf_pkg::REG_B_UPPER: begin
                    r_b_upper <= i_cfg_data[bicdf_pkg::B_W-1:0];
                end
                bicdf_pkg::REG_B_RECIP: begin
                    r_b_recip <= i_cfg_data[bicdf_pkg::RECIP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    bicdf_coord u_coord (
        .i_clk          (i_clk),
        .i_en1          (en1),
        .i_en2          (en2),
        .i_command      (i_command),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_write_value  (i_write_value),
        .i_shape_b      (i_shape_b),
        .i_probability  (i_probability),
        .i_b_lower      (r_b_lower),
        .i_b_upper      (r_b_upper),
        .i_b_recip      (r_b_recip),
        .o_coord        (coord)
    );

    // A write takes effect as its transaction leaves stage two.
    bicdf_table u_table (
        .i_clk   (i_clk),
        .i_en3   (en3),
        .i_wr_go (en3 && r_v2),
        .i_coord (coord),
        .o_fetch (fetch)
    );

    bicdf_interp u_interp (
        .i_clk           (i_clk),
        .i_en4           (en4),
        .i_en5           (en5),
        .i_fetch         (fetch),
        .o_reduced_angle (o_reduced_angle),
        .o_mean_square   (o_mean_square)
    );

endmodule

/* rtl/bicdf_checker.sv */
// ------------------------------------------------------------------------------------------
// bicdf_checker: port-level checks of the bilinear inverse-CDF lookup
// Watches the top-level ports and is bound to the top level.
// ------------------------------------------------------------------------------------------
module bicdf_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic [bicdf_pkg::CMD_W-1:0]       i_command,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic [bicdf_pkg::ANG_W-1:0]       o_reduced_angle,
    input  logic [bicdf_pkg::MSQ_W-1:0]       o_mean_square
);

    logic lookup_acc;

    assign lookup_acc = i_valid && !o_stall && (i_command == bicdf_pkg::CMD_LOOKUP);

    // A held result does not change while the output is stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reduced_angle) && $stable(o_mean_square))
        else $error("result changed while stalled");

    // The angle never exceeds its ceiling.
    a_angle_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_reduced_angle <= bicdf_pkg::ANGLE_MAX)
        else $error("reduced angle above ceiling");

    // With the output stage empty the pipeline can always take input.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output stage");

    // An accepted lookup reaches the output stage when the output is not stalled on its way.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lookup_acc ##1 !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("lookup result missing");

endmodule

bind bilinear_inverse_cdf_lookup_top bicdf_checker u_bicdf_checker (.*);
